### design/triangle_validity_and_volume_stats_core_macros.svh
// Assertion macros for the checker of the triangle statistics core.
// The clock and reset names clk_i and rst_ni must be visible at the point of use.
`ifndef TRIANGLE_VALIDITY_AND_VOLUME_STATS_CORE_MACROS_SVH
`define TRIANGLE_VALIDITY_AND_VOLUME_STATS_CORE_MACROS_SVH

// Checked only while out of reset.
`define TVS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TVS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/tvs_pkg.sv
// Shared constants, types and the multiply schedule of the triangle statistics core.
// No dependencies.
`timescale 1ns / 1ps
package tvs_pkg;

  localparam int unsigned COORD_BITS_DEF  = 20;
  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Fixed port widths
  localparam int unsigned COORD_W  = 20;
  localparam int unsigned MASK_W   = 9;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned VOL_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NUM_CRD  = 9;

  // Queue word layout, in units of one coordinate: nine coordinates, three low bounds,
  // three high bounds, then the nonfinite flag and the first-of-mesh flag.
  localparam int unsigned SLOT_LO    = 9;
  localparam int unsigned SLOT_HI    = 12;
  localparam int unsigned SLOT_FLAGS = 15;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID      = 2'd0,
    ST_NONFINITE  = 2'd1,
    ST_DEGENERATE = 2'd2
  } status_e;

  // Multiply schedule: 6 products for the edge cross product, 9 for a.(b x c)
  localparam int unsigned NUM_OPS = 15;
  localparam int unsigned OP_W    = 4;

  typedef enum logic [1:0] {
    K_LOAD,      // part = product
    K_SUB,       // part = part - product
    K_SUB_TEST,  // same, and flag a nonzero cross component
    K_MAC        // triple += product
  } op_kind_e;

  typedef enum logic [3:0] {
    A_U0, A_U1, A_U2, A_A0, A_A1, A_A2, A_B0, A_B1, A_B2
  } opa_e;

  typedef enum logic [2:0] {
    B_W0, B_W1, B_W2, B_C0, B_C1, B_C2, B_PART
  } opb_e;

  typedef struct packed {
    op_kind_e kind;
    opa_e     sel_a;
    opb_e     sel_b;
  } op_t;

  function automatic op_t op_lookup(logic [OP_W-1:0] idx);
    op_t op;
    case (idx)
      4'd0:    op = '{K_LOAD,     A_U1, B_W2};
      4'd1:    op = '{K_SUB_TEST, A_U2, B_W1};
      4'd2:    op = '{K_LOAD,     A_U2, B_W0};
      4'd3:    op = '{K_SUB_TEST, A_U0, B_W2};
      4'd4:    op = '{K_LOAD,     A_U0, B_W1};
      4'd5:    op = '{K_SUB_TEST, A_U1, B_W0};
      4'd6:    op = '{K_LOAD,     A_B1, B_C2};
      4'd7:    op = '{K_SUB,      A_B2, B_C1};
      4'd8:    op = '{K_MAC,      A_A0, B_PART};
      4'd9:    op = '{K_LOAD,     A_B2, B_C0};
      4'd10:   op = '{K_SUB,      A_B0, B_C2};
      4'd11:   op = '{K_MAC,      A_A1, B_PART};
      4'd12:   op = '{K_LOAD,     A_B0, B_C1};
      4'd13:   op = '{K_SUB,      A_B1, B_C0};
      4'd14:   op = '{K_MAC,      A_A2, B_PART};
      default: op = '{K_LOAD,     A_U0, B_W0};
    endcase
    return op;
  endfunction

endpackage

### design/tvs_front.sv
// Front end: takes triangles, flags nonfinite ones and keeps the bounding box.
// Depends on tvs_pkg. Feeds tvs_queue.
`timescale 1ns / 1ps
module tvs_front #(
  parameter int unsigned COORD_BITS = tvs_pkg::COORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic                                             first_of_mesh_i,
  input  logic [tvs_pkg::MASK_W-1:0]                       nonfinite_mask_i,
  input  logic [tvs_pkg::COORD_W-1:0]                      crd_i [tvs_pkg::NUM_CRD],
  output logic                                             push_valid_o,
  input  logic                                             push_ready_i,
  output logic [tvs_pkg::SLOT_FLAGS*COORD_BITS+1:0]        push_data_o
);
  import tvs_pkg::*;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] crd [NUM_CRD];
  logic signed [COORD_BITS-1:0] lo_q [3];
  logic signed [COORD_BITS-1:0] hi_q [3];
  logic signed [COORD_BITS-1:0] lo_d [3];
  logic signed [COORD_BITS-1:0] hi_d [3];
  logic                         accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // Bounds after this triangle; a first-of-mesh word starts from the empty box
  always_comb begin
    for (int i = 0; i < NUM_CRD; i++) begin
      crd[i] = crd_i[i][COORD_BITS-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      lo_d[k] = first_of_mesh_i ? C_MAX : lo_q[k];
      hi_d[k] = first_of_mesh_i ? C_MIN : hi_q[k];
      for (int j = 0; j < 3; j++) begin
        if (!nonfinite_mask_i[3*j+k]) begin
          if (crd[3*j+k] < lo_d[k]) lo_d[k] = crd[3*j+k];
          if (crd[3*j+k] > hi_d[k]) hi_d[k] = crd[3*j+k];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CRD; i++) begin
      push_data_o[i*COORD_BITS +: COORD_BITS] = crd[i];
    end
    for (int k = 0; k < 3; k++) begin
      push_data_o[(SLOT_LO+k)*COORD_BITS +: COORD_BITS] = lo_d[k];
      push_data_o[(SLOT_HI+k)*COORD_BITS +: COORD_BITS] = hi_d[k];
    end
    push_data_o[SLOT_FLAGS*COORD_BITS]     = |nonfinite_mask_i;
    push_data_o[SLOT_FLAGS*COORD_BITS + 1] = first_of_mesh_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= C_MAX;
        hi_q[k] <= C_MIN;
      end
    end else if (accept) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= lo_d[k];
        hi_q[k] <= hi_d[k];
      end
    end
  end

endmodule

### design/tvs_queue.sv
// Small register FIFO between the front end and the arithmetic back end.
// Depends on tvs_pkg for its default depth.
`timescale 1ns / 1ps
module tvs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tvs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import tvs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### design/tvs_back.sv
// Back end: degenerate test, triple product through one shared multiplier,
// saturating counts and volume sum, and the output register. Depends on tvs_pkg.
`timescale 1ns / 1ps
module tvs_back #(
  parameter int unsigned COORD_BITS = tvs_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = tvs_pkg::COUNT_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      pop_valid_i,
  output logic                                      pop_ready_o,
  input  logic [tvs_pkg::SLOT_FLAGS*COORD_BITS+1:0] pop_data_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [tvs_pkg::STATUS_W-1:0]              triangle_status_o,
  output logic [tvs_pkg::TOTAL_W-1:0]               nonfinite_total_o,
  output logic [tvs_pkg::TOTAL_W-1:0]               degenerate_total_o,
  output logic signed [tvs_pkg::VOL_W-1:0]          volume_times_six_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        min_x_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        min_y_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        min_z_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        max_x_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        max_y_o,
  output logic signed [tvs_pkg::COORD_W-1:0]        max_z_o
);
  import tvs_pkg::*;

  localparam int unsigned AW  = COORD_BITS + 1;      // edge vector / A operand
  localparam int unsigned PTW = 2*COORD_BITS + 3;    // partial difference / B operand
  localparam int unsigned PW  = AW + PTW;            // product
  localparam logic signed [VOL_W-1:0] V_MAX = {1'b0, {(VOL_W-1){1'b1}}};
  localparam logic signed [VOL_W-1:0] V_MIN = {1'b1, {(VOL_W-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_FIN, S_OUT} state_e;

  state_e                    state_q;
  logic [OP_W-1:0]           op_q;
  logic                      nz_q;
  status_e                   status_q;
  logic [COUNT_BITS-1:0]     nf_cnt_q, dg_cnt_q;
  logic signed [VOL_W-1:0]   vol_q;

  logic signed [COORD_BITS-1:0] crd_q [NUM_CRD];
  logic signed [COORD_BITS-1:0] bnd_q [6];
  logic signed [AW-1:0]         u_q [3];
  logic signed [AW-1:0]         w_q [3];
  logic signed [PW-1:0]         prod_q;
  logic signed [PTW-1:0]        part_q;
  logic signed [VOL_W-1:0]      tri_q;

  logic signed [COORD_BITS-1:0] e_crd [NUM_CRD];
  logic signed [COORD_BITS-1:0] e_bnd [6];
  logic                         e_nonfinite, e_first, pop;
  logic [COUNT_BITS-1:0]        nf_base;
  op_t                          cur_op;
  logic signed [AW-1:0]         opa;
  logic signed [PTW-1:0]        opb;
  logic signed [PTW-1:0]        part_diff;
  logic signed [VOL_W-1:0]      vol_sum, vol_sat;
  logic                         vol_ovf;
  logic [TOTAL_W-1:0]           nf_total, dg_total;

  always_comb begin
    for (int i = 0; i < NUM_CRD; i++) begin
      e_crd[i] = pop_data_i[i*COORD_BITS +: COORD_BITS];
    end
    for (int k = 0; k < 6; k++) begin
      e_bnd[k] = pop_data_i[(SLOT_LO+k)*COORD_BITS +: COORD_BITS];
    end
    e_nonfinite = pop_data_i[SLOT_FLAGS*COORD_BITS];
    e_first     = pop_data_i[SLOT_FLAGS*COORD_BITS + 1];
  end

  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign nf_base     = e_first ? '0 : nf_cnt_q;

  // Operand select for the shared multiplier
  always_comb begin
    cur_op = op_lookup(op_q);
    case (cur_op.sel_a)
      A_U0:    opa = u_q[0];
      A_U1:    opa = u_q[1];
      A_U2:    opa = u_q[2];
      A_A0:    opa = AW'(crd_q[0]);
      A_A1:    opa = AW'(crd_q[1]);
      A_A2:    opa = AW'(crd_q[2]);
      A_B0:    opa = AW'(crd_q[3]);
      A_B1:    opa = AW'(crd_q[4]);
      A_B2:    opa = AW'(crd_q[5]);
      default: opa = '0;
    endcase
    case (cur_op.sel_b)
      B_W0:    opb = PTW'(w_q[0]);
      B_W1:    opb = PTW'(w_q[1]);
      B_W2:    opb = PTW'(w_q[2]);
      B_C0:    opb = PTW'(crd_q[6]);
      B_C1:    opb = PTW'(crd_q[7]);
      B_C2:    opb = PTW'(crd_q[8]);
      B_PART:  opb = part_q;
      default: opb = '0;
    endcase
  end

  assign part_diff = part_q - prod_q[PTW-1:0];

  // Saturating volume add: overflow only when both signs agree and the sum flips
  assign vol_sum = vol_q + tri_q;
  assign vol_ovf = (vol_q[VOL_W-1] == tri_q[VOL_W-1]) && (vol_sum[VOL_W-1] != vol_q[VOL_W-1]);
  assign vol_sat = vol_ovf ? (tri_q[VOL_W-1] ? V_MIN : V_MAX) : vol_sum;

  if (COUNT_BITS > TOTAL_W) begin : g_wide_cnt
    assign nf_total = (|nf_cnt_q[COUNT_BITS-1:TOTAL_W]) ? '1 : nf_cnt_q[TOTAL_W-1:0];
    assign dg_total = (|dg_cnt_q[COUNT_BITS-1:TOTAL_W]) ? '1 : dg_cnt_q[TOTAL_W-1:0];
  end else begin : g_narrow_cnt
    assign nf_total = TOTAL_W'(nf_cnt_q);
    assign dg_total = TOTAL_W'(dg_cnt_q);
  end

  // Control, statistics and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      op_q               <= '0;
      nz_q               <= 1'b0;
      status_q           <= ST_VALID;
      nf_cnt_q           <= '0;
      dg_cnt_q           <= '0;
      vol_q              <= '0;
      out_valid_o        <= 1'b0;
      triangle_status_o  <= '0;
      nonfinite_total_o  <= '0;
      degenerate_total_o <= '0;
      volume_times_six_o <= '0;
      min_x_o            <= '0;
      min_y_o            <= '0;
      min_z_o            <= '0;
      max_x_o            <= '0;
      max_y_o            <= '0;
      max_z_o            <= '0;
    end else begin
      if (out_ready_i && state_q != S_OUT) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (e_first) begin
              dg_cnt_q <= '0;
              vol_q    <= '0;
            end
            nf_cnt_q <= (e_nonfinite && nf_base != '1) ? nf_base + 1'b1 : nf_base;
            op_q     <= '0;
            nz_q     <= 1'b0;
            status_q <= ST_NONFINITE;
            state_q  <= e_nonfinite ? S_OUT : S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (cur_op.kind == K_SUB_TEST && part_diff != '0) nz_q <= 1'b1;
          if (op_q == OP_W'(NUM_OPS-1)) begin
            state_q <= S_FIN;
          end else begin
            op_q    <= op_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          status_q <= nz_q ? ST_VALID : ST_DEGENERATE;
          if (!nz_q && dg_cnt_q != '1) dg_cnt_q <= dg_cnt_q + 1'b1;
          vol_q   <= vol_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o        <= 1'b1;
            triangle_status_o  <= status_q;
            nonfinite_total_o  <= nf_total;
            degenerate_total_o <= dg_total;
            volume_times_six_o <= vol_q;
            min_x_o            <= COORD_W'(bnd_q[0]);
            min_y_o            <= COORD_W'(bnd_q[1]);
            min_z_o            <= COORD_W'(bnd_q[2]);
            max_x_o            <= COORD_W'(bnd_q[3]);
            max_y_o            <= COORD_W'(bnd_q[4]);
            max_z_o            <= COORD_W'(bnd_q[5]);
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          for (int i = 0; i < NUM_CRD; i++) crd_q[i] <= e_crd[i];
          for (int k = 0; k < 6; k++) bnd_q[k] <= e_bnd[k];
          for (int k = 0; k < 3; k++) begin
            u_q[k] <= AW'(e_crd[3+k]) - AW'(e_crd[k]);
            w_q[k] <= AW'(e_crd[6+k]) - AW'(e_crd[k]);
          end
          tri_q <= '0;
        end
      end
      S_MUL: prod_q <= PW'(opa) * PW'(opb);
      S_ACC: begin
        case (cur_op.kind)
          K_LOAD:     part_q <= prod_q[PTW-1:0];
          K_SUB:      part_q <= part_diff;
          K_SUB_TEST: part_q <= part_diff;
          K_MAC:      tri_q  <= tri_q + VOL_W'(prod_q);
          default:    part_q <= part_q;
        endcase
      end
      default: tri_q <= tri_q;
    endcase
  end

endmodule

### design/triangle_validity_and_volume_stats_core.sv
// Triangle statistics core: usage notes.
// Input channel: one word per triangle (nine signed coordinates, nonfinite mask,
// first_of_mesh), valid/ready. Output channel: one word per triangle with its status
// and the running totals, bounds and six-times-volume sum after that triangle.
// Only the low COORD_BITS bits of each coordinate are used.
// The front end classifies and updates the bounding box as it takes a word, then
// pushes it into a two-word queue; it keeps taking words while the queue has room.
// The back end runs 15 products through one 21 x 43 bit multiplier, each as a
// multiply step and then an accumulate step (S_MUL, S_ACC); a finite triangle then
// passes S_FIN and S_OUT, a nonfinite one goes from S_IDLE straight to S_OUT. The
// back end pops a new triangle only in S_IDLE, once the last word is registered.
// The output word sits in a register; while the receiver stalls the back end holds
// its finished word and the queue and front end keep filling.
// Reset clears counts and volume to zero and the box to empty (low bound at the
// largest value, high bound at the smallest). first_of_mesh does the same just
// before its own triangle is counted.
// Files: tvs_pkg, tvs_front, tvs_queue, tvs_back.
`timescale 1ns / 1ps
module triangle_validity_and_volume_stats_core #(
  parameter int unsigned COORD_BITS = tvs_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = tvs_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               first_of_mesh_i,
  input  logic [tvs_pkg::MASK_W-1:0]         nonfinite_mask_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] ax_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] ay_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] az_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] bx_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] by_coord_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] bz_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] cx_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] cy_i,
  input  logic signed [tvs_pkg::COORD_W-1:0] cz_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tvs_pkg::STATUS_W-1:0]       triangle_status_o,
  output logic [tvs_pkg::TOTAL_W-1:0]        nonfinite_total_o,
  output logic [tvs_pkg::TOTAL_W-1:0]        degenerate_total_o,
  output logic signed [tvs_pkg::VOL_W-1:0]   volume_times_six_o,
  output logic signed [tvs_pkg::COORD_W-1:0] min_x_o,
  output logic signed [tvs_pkg::COORD_W-1:0] min_y_o,
  output logic signed [tvs_pkg::COORD_W-1:0] min_z_o,
  output logic signed [tvs_pkg::COORD_W-1:0] max_x_o,
  output logic signed [tvs_pkg::COORD_W-1:0] max_y_o,
  output logic signed [tvs_pkg::COORD_W-1:0] max_z_o
);
  import tvs_pkg::*;

  localparam int unsigned ENTRY_W = SLOT_FLAGS*COORD_BITS + 2;

  logic [COORD_W-1:0] crd [NUM_CRD];
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  assign crd = '{ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i};

  tvs_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_of_mesh_i  (first_of_mesh_i),
    .nonfinite_mask_i (nonfinite_mask_i),
    .crd_i            (crd),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  tvs_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tvs_back #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_ready_o        (pop_ready),
    .pop_data_i         (pop_data),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .triangle_status_o  (triangle_status_o),
    .nonfinite_total_o  (nonfinite_total_o),
    .degenerate_total_o (degenerate_total_o),
    .volume_times_six_o (volume_times_six_o),
    .min_x_o            (min_x_o),
    .min_y_o            (min_y_o),
    .min_z_o            (min_z_o),
    .max_x_o            (max_x_o),
    .max_y_o            (max_y_o),
    .max_z_o            (max_z_o)
  );

endmodule

### design/tvs_checker.sv
// Port-level checks for the triangle statistics core, bound to the top level.
// Depends on tvs_pkg and triangle_validity_and_volume_stats_core_macros.svh.
`timescale 1ns / 1ps
`include "triangle_validity_and_volume_stats_core_macros.svh"
module tvs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [tvs_pkg::STATUS_W-1:0]       triangle_status_o,
  input logic [tvs_pkg::TOTAL_W-1:0]        nonfinite_total_o,
  input logic [tvs_pkg::TOTAL_W-1:0]        degenerate_total_o,
  input logic signed [tvs_pkg::VOL_W-1:0]   volume_times_six_o,
  input logic signed [tvs_pkg::COORD_W-1:0] min_x_o,
  input logic signed [tvs_pkg::COORD_W-1:0] min_y_o,
  input logic signed [tvs_pkg::COORD_W-1:0] min_z_o,
  input logic signed [tvs_pkg::COORD_W-1:0] max_x_o,
  input logic signed [tvs_pkg::COORD_W-1:0] max_y_o,
  input logic signed [tvs_pkg::COORD_W-1:0] max_z_o
);
  import tvs_pkg::*;

  // A stalled output word holds
  `TVS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(triangle_status_o) && $stable(volume_times_six_o), "output word changed while stalled")

  // A nonfinite word has already been counted
  `TVS_ASSERT(a_nf_counted, out_valid_o && triangle_status_o == ST_NONFINITE |-> nonfinite_total_o != '0, "nonfinite word with zero nonfinite total")

  `TVS_ASSERT(a_dg_counted, out_valid_o && triangle_status_o == ST_DEGENERATE |-> degenerate_total_o != '0, "degenerate word with zero degenerate total")

  // An all-finite triangle puts its own vertices in the box, so it cannot be empty
  `TVS_ASSERT(a_box_nonempty, out_valid_o && triangle_status_o != ST_NONFINITE |-> min_x_o <= max_x_o && min_y_o <= max_y_o && min_z_o <= max_z_o, "empty box after finite triangle")

  // Output valid is cleared by reset and is still low right after it
  `TVS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule

bind triangle_validity_and_volume_stats_core tvs_checker u_tvs_checker (.*);
